[design/plist_pkg.sv]
// Shared types for the positional list engine: operation and status codes,
// sequencer states and the result group handed to the output stage.
// No dependencies.
`timescale 1ns / 1ps

package plist_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_FIND,
    S_DONE
  } state_t;

  // Finished-result handoff from the sequencer
  typedef struct packed {
    logic    done;
    status_t status;
  } res_t;

endpackage

[design/positional_list_engine.sv]
// Top level of the positional list engine: sequencer, entry RAM and the
// output register. Depends on plist_pkg, plist_seq and plist_ram.
`timescale 1ns / 1ps

// A bounded ordered list of up to LIST_DEPTH signed words kept in one
// RAM with a registered read. One request is worked at a time; the entry
// RAM's single read port moves one word per cycle. An insert shifts the
// entries at and above its position up, then writes the word; a delete
// shifts the entries above its position down; a find scans up from entry 0
// and stops at the first match; clear and rejected requests skip the RAM.
// The result sits in an output register, so the next request is taken
// while an earlier result still waits for out_ready. No clearing pass is
// needed after reset: only entries below the count are ever read.
module positional_list_engine #(
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   position,
  input  logic [VALUE_WIDTH-1:0]            value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [$clog2(LIST_DEPTH)-1:0]     found_index,
  output logic [$clog2(LIST_DEPTH+1)-1:0]   element_total,
  output logic                              is_empty
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [VALUE_WIDTH-1:0] mem_rd_data;

  plist_pkg::res_t res;
  logic [AW-1:0]   res_idx;
  logic [CW-1:0]   res_total;
  logic            res_take;

  plist_seq #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .position    (position),
    .value       (value),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res         (res),
    .res_idx     (res_idx),
    .res_total   (res_total),
    .res_take    (res_take)
  );

  plist_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register takes a result when empty or when its beat leaves
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (res.done && res_take) begin
      status        <= res.status;
      found_index   <= res_idx;
      element_total <= res_total;
      is_empty      <= (res_total == '0);
    end
  end

endmodule

[design/plist_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/plist_seq.sv]
// Request sequencer: holds the entry count and walks the entry RAM one word
// a cycle to shift for insert/delete and to scan for find.
// Depends on plist_pkg.
`timescale 1ns / 1ps

module plist_seq #(
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   position,
  input  logic [VALUE_WIDTH-1:0]            value,
  // entry RAM
  output logic                              mem_wr_en,
  output logic [$clog2(LIST_DEPTH)-1:0]     mem_wr_addr,
  output logic [VALUE_WIDTH-1:0]            mem_wr_data,
  output logic                              mem_rd_en,
  output logic [$clog2(LIST_DEPTH)-1:0]     mem_rd_addr,
  input  logic [VALUE_WIDTH-1:0]            mem_rd_data,
  // result handoff
  output plist_pkg::res_t                   res,
  output logic [$clog2(LIST_DEPTH)-1:0]     res_idx,
  output logic [$clog2(LIST_DEPTH+1)-1:0]   res_total,
  input  logic                              res_take
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  plist_pkg::state_t  state, state_next;
  plist_pkg::status_t status_r, status_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      rd_addr, rd_addr_next;
  logic [AW-1:0]      pos, pos_next;
  logic [AW-1:0]      idx, idx_next;
  logic [VALUE_WIDTH-1:0] val, val_next;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_addr;
  logic [AW-1:0] pos_in;

  assign cnt_m1    = count - CW'(1);
  assign last_addr = cnt_m1[AW-1:0];
  assign pos_in    = position[AW-1:0];

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plist_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_next;
    rd_addr  <= rd_addr_next;
    pos      <= pos_next;
    idx      <= idx_next;
    val      <= val_next;
  end

  // Next state, RAM access and result
  always_comb begin
    state_next   = state;
    count_next   = count;
    rd_addr_next = rd_addr;
    pos_next     = pos;
    idx_next     = idx;
    val_next     = val;
    status_next  = status_r;
    in_ready     = (state == plist_pkg::S_IDLE);
    mem_rd_en    = 1'b0;
    mem_rd_addr  = rd_addr;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = rd_addr;
    mem_wr_data  = mem_rd_data;

    case (state)
      plist_pkg::S_IDLE: begin
        if (in_valid) begin
          val_next    = value;
          pos_next    = pos_in;
          idx_next    = '0;
          status_next = plist_pkg::ST_OK;
          state_next  = plist_pkg::S_DONE;
          case (plist_pkg::kind_t'(kind))
            plist_pkg::OP_INSERT: begin
              if (count == CW'(LIST_DEPTH)) begin
                status_next = plist_pkg::ST_FULL;
              end else if (position > count) begin
                status_next = plist_pkg::ST_BAD_POS;
              end else if (position == count) begin
                state_next = plist_pkg::S_INS_PUT;
              end else begin
                // start at the top entry and walk down
                mem_rd_en    = 1'b1;
                mem_rd_addr  = last_addr;
                rd_addr_next = last_addr;
                state_next   = plist_pkg::S_INS_SHIFT;
              end
            end
            plist_pkg::OP_DELETE: begin
              if (position >= count) begin
                status_next = plist_pkg::ST_BAD_POS;
              end else if (position == cnt_m1) begin
                count_next = cnt_m1;
              end else begin
                // start just above the removed entry and walk up
                mem_rd_en    = 1'b1;
                mem_rd_addr  = pos_in + AW'(1);
                rd_addr_next = pos_in + AW'(1);
                state_next   = plist_pkg::S_DEL_SHIFT;
              end
            end
            plist_pkg::OP_FIND: begin
              if (count == '0) begin
                status_next = plist_pkg::ST_NOT_FOUND;
              end else begin
                mem_rd_en    = 1'b1;
                mem_rd_addr  = '0;
                rd_addr_next = '0;
                state_next   = plist_pkg::S_FIND;
              end
            end
            plist_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      plist_pkg::S_INS_SHIFT: begin
        // move the word just read up by one
        mem_wr_en   = 1'b1;
        mem_wr_addr = rd_addr + AW'(1);
        if (rd_addr == pos) begin
          state_next = plist_pkg::S_INS_PUT;
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_addr - AW'(1);
          rd_addr_next = rd_addr - AW'(1);
        end
      end

      plist_pkg::S_INS_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos;
        mem_wr_data = val;
        count_next  = count + CW'(1);
        state_next  = plist_pkg::S_DONE;
      end

      plist_pkg::S_DEL_SHIFT: begin
        // move the word just read down by one
        mem_wr_en   = 1'b1;
        mem_wr_addr = rd_addr - AW'(1);
        if (rd_addr == last_addr) begin
          count_next = cnt_m1;
          state_next = plist_pkg::S_DONE;
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_addr + AW'(1);
          rd_addr_next = rd_addr + AW'(1);
        end
      end

      plist_pkg::S_FIND: begin
        if (mem_rd_data == val) begin
          idx_next   = rd_addr;
          state_next = plist_pkg::S_DONE;
        end else if (rd_addr == last_addr) begin
          status_next = plist_pkg::ST_NOT_FOUND;
          state_next  = plist_pkg::S_DONE;
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_addr + AW'(1);
          rd_addr_next = rd_addr + AW'(1);
        end
      end

      plist_pkg::S_DONE: begin
        // hold until the output register can take the result
        if (res_take) begin
          state_next = plist_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = plist_pkg::S_IDLE;
      end
    endcase
  end

  assign res.done   = (state == plist_pkg::S_DONE);
  assign res.status = status_r;
  assign res_idx    = idx;
  assign res_total  = count;

endmodule

[design/plist_checker.sv]
// Port-level checks for the positional list engine, bound to the top level.
// Depends on plist_pkg and positional_list_engine.
`timescale 1ns / 1ps

module plist_checker #(
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        status,
  input logic [$clog2(LIST_DEPTH)-1:0]     found_index,
  input logic [$clog2(LIST_DEPTH+1)-1:0]   element_total,
  input logic                              is_empty
);

  localparam int VW = VALUE_WIDTH;

  // Only one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in work (width %0d)", VW);

  // Empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (element_total == '0)))
    else $error("empty flag disagrees with element total");

  // A full report only comes with a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == plist_pkg::ST_FULL) |-> (element_total == LIST_DEPTH))
    else $error("full status with list not full");

  // Index is zero unless a find succeeded
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != plist_pkg::ST_OK) |-> (found_index == '0))
    else $error("nonzero index on failed request");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)
      && $stable(found_index) && $stable(element_total)))
    else $error("stalled result beat changed");

endmodule

bind positional_list_engine plist_checker #(
  .LIST_DEPTH  (LIST_DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_plist_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for positional_list_engine: directed and random list
// requests with a built-in list predictor and a scoreboard of predicted results.
// Depends on plist_pkg and the design files of the list engine.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH         = 64;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int TAIL_ITEMS    = 150;
  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT   = 4000;

  typedef struct packed {
    plist_pkg::kind_t op;
    logic [6:0]       pos;
    logic [31:0]      word;
    logic             wait_drain;
  } list_request_t;

  typedef struct packed {
    plist_pkg::status_t status;
    logic [5:0]         index;
    logic [6:0]         total;
    logic               empty;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = 2'd0;
  logic [6:0]  position = 7'd0;
  logic [31:0] value = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [5:0]  found_index;
  logic [6:0]  element_total;
  logic        is_empty;

  positional_list_engine uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .position     (position),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_index  (found_index),
    .element_total(element_total),
    .is_empty     (is_empty)
  );

  // Predictor state: shadow list contents and entry count
  logic [31:0] list_words [DEPTH];
  int          list_count = 0;

  list_request_t list_requests[$];
  list_result_t  predicted_results[$];

  int   accepted_total = 0;
  int   retired_total = 0;
  int   fail_count = 0;
  int   quiet_cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  logic calm = 1'b0;
  logic feed_done = 1'b0;

  // Stimulus-side bookkeeping: running count and a pool of reused words
  int          gen_count = 0;
  int          gen_items = 0;
  logic [31:0] word_pool [16];

  // Apply one request to the shadow list and return the result it produces
  function automatic list_result_t list_op_outcome(input list_request_t req);
    list_result_t r;
    int i;
    r.status = plist_pkg::ST_OK;
    r.index  = '0;
    case (req.op)
      plist_pkg::OP_INSERT: begin
        if (list_count >= DEPTH) begin
          r.status = plist_pkg::ST_FULL;
        end else if (req.pos > list_count) begin
          r.status = plist_pkg::ST_BAD_POS;
        end else begin
          for (i = list_count; i > req.pos; i--) list_words[i] = list_words[i-1];
          list_words[req.pos] = req.word;
          list_count++;
        end
      end
      plist_pkg::OP_DELETE: begin
        if (req.pos >= list_count) begin
          r.status = plist_pkg::ST_BAD_POS;
        end else begin
          for (i = req.pos + 1; i < list_count; i++) list_words[i-1] = list_words[i];
          list_count--;
        end
      end
      plist_pkg::OP_FIND: begin
        // scan downward so the lowest matching index wins
        r.status = plist_pkg::ST_NOT_FOUND;
        for (i = list_count - 1; i >= 0; i--) begin
          if (list_words[i] == req.word) begin
            r.status = plist_pkg::ST_OK;
            r.index  = 6'(i);
          end
        end
      end
      default: begin
        list_count = 0;
      end
    endcase
    r.total = 7'(list_count);
    r.empty = (list_count == 0);
    return r;
  endfunction

  task automatic queue_request(input plist_pkg::kind_t op, input int pos,
                               input logic [31:0] word, input logic wait_drain);
    list_request_t req;
    req.op         = op;
    req.pos        = 7'(pos);
    req.word       = word;
    req.wait_drain = wait_drain;
    list_requests.push_back(req);
    gen_items++;
    case (op)
      plist_pkg::OP_INSERT: if (gen_count < DEPTH && req.pos <= gen_count) gen_count++;
      plist_pkg::OP_DELETE: if (req.pos < gen_count) gen_count--;
      plist_pkg::OP_CLEAR:  gen_count = 0;
      default:   ;
    endcase
  endtask

  function automatic logic [31:0] pick_word(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return word_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // Clock and reset
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Build the stimulus: directed cases first, then random phases
  initial begin
    int phase;
    int span;
    int roll;
    int pos;
    int ins_pct;
    int del_pct;
    int find_pct;
    plist_pkg::kind_t op;
    logic drain;

    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7fff_ffff;
    word_pool[2] = 32'h0000_0000;
    word_pool[3] = 32'hffff_ffff;
    word_pool[4] = 32'h0000_0001;
    for (int k = 5; k < 16; k++) word_pool[k] = $urandom;

    // empty-list corner cases
    queue_request(plist_pkg::OP_DELETE, 0, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_FIND, 0, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_CLEAR, 0, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_INSERT, 1, 32'h5, 1'b0);
    // front, middle, append and out-of-range inserts with extreme words
    queue_request(plist_pkg::OP_INSERT, 0, 32'h8000_0000, 1'b0);
    queue_request(plist_pkg::OP_INSERT, 1, 32'h7fff_ffff, 1'b0);
    queue_request(plist_pkg::OP_INSERT, 0, 32'hffff_ffff, 1'b0);
    queue_request(plist_pkg::OP_INSERT, 1, 32'h0000_0000, 1'b0);
    queue_request(plist_pkg::OP_INSERT, 127, 32'h1, 1'b0);
    queue_request(plist_pkg::OP_INSERT, 4, 32'hffff_ffff, 1'b0);
    // find: duplicate returns lowest index, extremes, and a miss
    queue_request(plist_pkg::OP_FIND, 127, 32'hffff_ffff, 1'b0);
    queue_request(plist_pkg::OP_FIND, 0, 32'h7fff_ffff, 1'b0);
    queue_request(plist_pkg::OP_FIND, 0, 32'h8000_0000, 1'b0);
    queue_request(plist_pkg::OP_FIND, 0, 32'h1234_5678, 1'b0);
    // delete at count, far out of range, then last, first and middle
    queue_request(plist_pkg::OP_DELETE, 5, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_DELETE, 127, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_DELETE, 4, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_DELETE, 0, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_DELETE, 1, 32'h0, 1'b0);
    queue_request(plist_pkg::OP_FIND, 0, 32'hffff_ffff, 1'b0);
    // clear a populated list after a full drain, then look for a stale word
    queue_request(plist_pkg::OP_CLEAR, 99, 32'hdead_beef, 1'b1);
    queue_request(plist_pkg::OP_FIND, 0, 32'h0000_0000, 1'b0);

    // random phases: grow, shrink, mixed
    gen_items = 0;
    phase = 0;
    while (gen_items < RANDOM_ITEMS) begin
      span = (gen_items == 0) ? 120 : $urandom_range(20, 120);
      case (phase)
        0:       begin ins_pct = 70; del_pct = 10; find_pct = 18; end
        1:       begin ins_pct = 15; del_pct = 65; find_pct = 18; end
        default: begin ins_pct = 35; del_pct = 30; find_pct = 30; end
      endcase
      drain = (gen_items == 0) || ($urandom_range(0, 2) == 0);
      for (int n = 0; n < span; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) op = plist_pkg::OP_INSERT;
        else if (roll < ins_pct + del_pct) op = plist_pkg::OP_DELETE;
        else if (roll < ins_pct + del_pct + find_pct) op = plist_pkg::OP_FIND;
        else op = plist_pkg::OP_CLEAR;
        // mostly legal positions, some noise across the whole field
        if ($urandom_range(0, 9) == 0 || op == plist_pkg::OP_FIND ||
            op == plist_pkg::OP_CLEAR) begin
          pos = $urandom_range(0, 127);
        end else if (op == plist_pkg::OP_INSERT) begin
          pos = $urandom_range(0, gen_count);
        end else begin
          pos = (gen_count == 0) ? 0 : $urandom_range(0, gen_count - 1);
        end
        queue_request(op, pos, pick_word((op == plist_pkg::OP_FIND) ? 75 : 60),
                      drain && n == 0);
      end
      phase = $urandom_range(0, 2);
    end
  end

  // Driver: present requests, insert idle bursts, hold until accepted
  always @(posedge clk) begin : drive
    logic          took;
    list_request_t req;
    took = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        predicted_results.push_back(list_op_outcome(
          list_request_t'{plist_pkg::kind_t'(kind), position, value, 1'b0}));
        accepted_total <= accepted_total + 1;
      end
      calm <= (list_requests.size() < TAIL_ITEMS);
      if (in_valid && !took) begin
        // hold the current beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (list_requests.size() == 0) begin
        in_valid  <= 1'b0;
        feed_done <= 1'b1;
      end else if (list_requests[0].wait_drain &&
                   accepted_total + int'(took) != retired_total) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else begin
        req = list_requests.pop_front();
        in_valid <= 1'b1;
        kind     <= req.op;
        position <= req.pos;
        value    <= req.word;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin : check
    list_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        retired_total <= retired_total + 1;
        if (predicted_results.size() == 0) begin
          $error("unexpected result beat: status %0d total %0d", status, element_total);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (found_index !== want.index) begin
            $error("found_index: expected %0d, actual %0d", want.index, found_index);
            fail_count++;
          end
          if (element_total !== want.total) begin
            $error("element_total: expected %0d, actual %0d", want.total, element_total);
            fail_count++;
          end
          if (is_empty !== want.empty) begin
            $error("is_empty: expected %0d, actual %0d", want.empty, is_empty);
            fail_count++;
          end
        end
      end
      // stall in random bursts, never in the tail of the run
      if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 14);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: abort when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End of run: drain, settle, report
  initial begin
    @(negedge clk);
    while (!(feed_done && accepted_total == retired_total)) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
